### src/pcrle_pkg.sv
`timescale 1ns / 1ps
// pcrle_pkg: shared widths, register indexes and types of the pixel channel
// run-length encoder. No dependencies.
package pcrle_pkg;

  localparam int CHAN_W     = 2;
  localparam int LIMIT_W    = 8;
  localparam int VAL_W      = 5;
  localparam int CNT_W      = 8;
  localparam int CODE_W     = 8;
  localparam int PIXEL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT      = 2'd1;

  localparam logic [CHAN_W-1:0]  CHANNEL_RESET = 2'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 8'd255;

  // runs of this length and longer take an escape byte plus a count byte
  localparam logic [CNT_W-1:0] ESCAPE_LEN  = 8'd7;
  localparam logic [2:0]       ESCAPE_CODE = 3'd7;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic [CNT_W-1:0] cnt;
  } run_desc_t;

  // one queue entry: up to two closed runs caused by one pixel
  // run_a: run closed by a value change or the limit
  // run_b: run flushed at end of frame
  typedef struct packed {
    logic      a_vld;
    run_desc_t run_a;
    logic      b_vld;
    run_desc_t run_b;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

### src/pixel_channel_run_length_encoder.sv
`timescale 1ns / 1ps
// pixel_channel_run_length_encoder: top level, joins front, entry queue and
// back. Uses pcrle_pkg, pcrle_front, pcrle_queue and pcrle_back.
//
// Run-length coder for one colour channel of a pixel stream. Each request
// carries a 32-bit pixel word; the byte picked by channel_select is cut to
// its top five bits and equal values are counted into runs, which close on
// a value change, on reaching run_limit, or at end of frame (the open run is
// then flushed and its last byte carries frame_done). A run of 1 to 6 gives
// one byte {value, count}; a longer one gives {value, 7} and a count byte.
// The front accepts one pixel every cycle and holds in_stall low while the
// entry queue (QUEUE_DEPTH entries, one per pixel that closes a run) has
// room. The back drains the queue at one code byte per cycle while out_stall
// is low, into an output register, so a stream whose code averages at most
// one byte per pixel runs at one pixel per cycle; a pixel can cause up to
// four bytes, and the queue absorbs bursts of those before in_stall rises.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must write it only while the block is idle, the block does not enforce it.
module pixel_channel_run_length_encoder #(
  parameter int QUEUE_DEPTH = pcrle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [pcrle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pcrle_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pcrle_pkg::PIXEL_W-1:0]     in_pixel_word,
  input  logic                              in_end_of_frame,
  // code byte requests
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcrle_pkg::CODE_W-1:0]      out_code_byte,
  output logic                              out_last_of_item,
  output logic                              out_frame_done
);

  logic                     accept;
  logic                     push;
  logic                     pop;
  pcrle_pkg::entry_t        push_entry;
  pcrle_pkg::entry_t        head;
  pcrle_pkg::queue_status_t status;

  // stall only when the queue could not take this pixel's entry
  assign in_stall = status.full;
  assign accept   = in_valid && !in_stall;

  pcrle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .pixel_word   (in_pixel_word),
    .end_of_frame (in_end_of_frame),
    .push         (push),
    .entry        (push_entry)
  );

  // entries hold closed runs; pixels that only extend a run push nothing
  pcrle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  pcrle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .status           (status),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_byte    (out_code_byte),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

  // the frame's final byte always closes the code of its pixel
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_item)
    else $error("frame_done without last_of_item");

  // an end-of-frame pixel always leaves a flush entry
  a_eof_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_frame |-> push)
    else $error("end of frame pixel pushed no entry");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue underflow");

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue overflow");

endmodule

### src/pcrle_front.sv
`timescale 1ns / 1ps
// pcrle_front: configuration registers, channel pick and run tracking;
// turns each pixel into a queue entry of closed runs. Uses pcrle_pkg.
module pcrle_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [pcrle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pcrle_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                                accept,
  input  logic [pcrle_pkg::PIXEL_W-1:0]       pixel_word,
  input  logic                                end_of_frame,
  output logic                                push,
  output pcrle_pkg::entry_t                   entry
);

  logic [pcrle_pkg::CHAN_W-1:0]  chan_sel_r;
  logic [pcrle_pkg::LIMIT_W-1:0] run_limit_r;
  logic [pcrle_pkg::VAL_W-1:0]   run_value_r, run_value_nxt;
  logic [pcrle_pkg::CNT_W-1:0]   run_count_r, run_count_nxt;
  logic                          started_r, started_nxt;

  logic [pcrle_pkg::VAL_W-1:0]   pix_val;
  logic                          extend;
  logic                          close_a;
  logic [pcrle_pkg::VAL_W-1:0]   open_val;
  logic [pcrle_pkg::CNT_W-1:0]   open_cnt;

  // top five bits of the chosen byte
  always_comb begin
    case (chan_sel_r)
      2'd0:    pix_val = pixel_word[7:3];
      2'd1:    pix_val = pixel_word[15:11];
      2'd2:    pix_val = pixel_word[23:19];
      default: pix_val = pixel_word[31:27];
    endcase
  end

  always_comb begin
    extend  = (pix_val == run_value_r) && (run_count_r < run_limit_r);
    close_a = started_r && !extend;
    open_val = pix_val;
    if (started_r && extend) begin
      open_cnt = run_count_r + 8'd1;
    end else begin
      open_cnt = 8'd1;
    end

    entry.a_vld     = close_a;
    entry.run_a.val = run_value_r;
    entry.run_a.cnt = run_count_r;
    entry.b_vld     = end_of_frame;
    entry.run_b.val = open_val;
    entry.run_b.cnt = open_cnt;
    push = accept && (close_a || end_of_frame);

    run_value_nxt = run_value_r;
    run_count_nxt = run_count_r;
    started_nxt   = started_r;
    if (accept) begin
      if (end_of_frame) begin
        run_value_nxt = '0;
        run_count_nxt = '0;
        started_nxt   = 1'b0;
      end else begin
        run_value_nxt = open_val;
        run_count_nxt = open_cnt;
        started_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_sel_r  <= pcrle_pkg::CHANNEL_RESET;
      run_limit_r <= pcrle_pkg::LIMIT_RESET;
      run_value_r <= '0;
      run_count_r <= '0;
      started_r   <= 1'b0;
    end else begin
      run_value_r <= run_value_nxt;
      run_count_r <= run_count_nxt;
      started_r   <= started_nxt;
      if (cfg_we && (cfg_index == pcrle_pkg::REG_CHANNEL_SELECT)) begin
        chan_sel_r <= cfg_data[pcrle_pkg::CHAN_W-1:0];
      end
      if (cfg_we && (cfg_index == pcrle_pkg::REG_RUN_LIMIT)) begin
        run_limit_r <= cfg_data[pcrle_pkg::LIMIT_W-1:0];
      end
    end
  end

endmodule

### src/pcrle_queue.sv
`timescale 1ns / 1ps
// pcrle_queue: small flip-flop queue of run entries between front and back.
// Uses pcrle_pkg.
module pcrle_queue #(
  parameter int DEPTH = pcrle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  pcrle_pkg::entry_t        push_entry,
  input  logic                     pop,
  output pcrle_pkg::entry_t        head,
  output pcrle_pkg::queue_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pcrle_pkg::entry_t slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
    head         = slot_r[rd_ptr_r];
    status.empty = (count_r == '0);
    status.full  = (count_r == FULL_CNT);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/pcrle_back.sv
`timescale 1ns / 1ps
// pcrle_back: expands queue entries into code bytes, one per cycle while
// out_stall is low, into the output register. Uses pcrle_pkg.
module pcrle_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcrle_pkg::entry_t                  head,
  input  pcrle_pkg::queue_status_t           status,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pcrle_pkg::CODE_W-1:0]       out_code_byte,
  output logic                               out_last_of_item,
  output logic                               out_frame_done
);

  logic seg_r, seg_nxt;   // 0: run_a, 1: run_b
  logic sub_r, sub_nxt;   // 0: first byte, 1: count byte
  logic out_valid_r, out_valid_nxt;
  logic [pcrle_pkg::CODE_W-1:0] code_r;
  logic last_r, done_r;

  logic                 load, emit, cur_seg, escape, run_end, entry_end;
  pcrle_pkg::run_desc_t cur;
  logic [pcrle_pkg::CODE_W-1:0] code_cur;

  always_comb begin
    load    = !out_valid_r || !out_stall;
    emit    = load && !status.empty;
    cur_seg = seg_r || !head.a_vld;
    cur     = cur_seg ? head.run_b : head.run_a;
    escape  = (cur.cnt >= pcrle_pkg::ESCAPE_LEN);
    if (sub_r) begin
      code_cur = cur.cnt;
    end else if (escape) begin
      code_cur = {cur.val, pcrle_pkg::ESCAPE_CODE};
    end else begin
      code_cur = {cur.val, cur.cnt[2:0]};
    end
    run_end   = sub_r || !escape;
    entry_end = run_end && (cur_seg || !head.b_vld);
    pop       = emit && entry_end;

    seg_nxt = seg_r;
    sub_nxt = sub_r;
    if (emit) begin
      if (entry_end) begin
        seg_nxt = 1'b0;
        sub_nxt = 1'b0;
      end else if (run_end) begin
        seg_nxt = 1'b1;
        sub_nxt = 1'b0;
      end else begin
        sub_nxt = 1'b1;
      end
    end
    out_valid_nxt = load ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      code_r <= code_cur;
      last_r <= entry_end;
      done_r <= entry_end && cur_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= 1'b0;
      sub_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seg_r       <= seg_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_code_byte    = code_r;
  assign out_last_of_item = last_r;
  assign out_frame_done   = done_r;

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for pixel_channel_run_length_encoder.
// Depends on pcrle_pkg and the encoder RTL; a scoreboard class predicts the
// code bytes of every accepted pixel request and checks them in order.
module testbench;
  import pcrle_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles with no handshake at all
  localparam int SETTLE_CYCLES = 8;     // quiet margin after the last owed byte
  localparam int PHASES        = 10;
  localparam int PHASE_PIXELS  = 22;
  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] UNUSED_REG_B = 2'd3;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              last;
    logic              done;
  } code_rec_t;

  // scoreboard: own copy of the encoder state and registers, plus the queue
  // of code bytes still owed by the block
  class rle_scoreboard;
    code_rec_t        owed_codes[$];
    code_rec_t        step_codes[$];
    logic [CHAN_W-1:0]  chan_sel;
    logic [LIMIT_W-1:0] limit;
    logic [VAL_W-1:0]   run_val;
    logic [CNT_W-1:0]   run_cnt;
    bit                 in_frame;
    int                 errors;
    int                 codes_seen;

    function new();
      chan_sel   = CHANNEL_RESET;
      limit      = LIMIT_RESET;
      run_val    = '0;
      run_cnt    = '0;
      in_frame   = 1'b0;
      errors     = 0;
      codes_seen = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CHANNEL_SELECT) begin
        chan_sel = data[CHAN_W-1:0];
      end else if (idx == REG_RUN_LIMIT) begin
        limit = data[LIMIT_W-1:0];
      end
    endfunction

    function int pending();
      return owed_codes.size();
    endfunction

    // code of the open run: one byte for short runs, escape plus count else
    function void close_run(bit done);
      logic [CODE_W-1:0] base;
      base = {run_val, 3'b000};
      if (run_cnt < ESCAPE_LEN) begin
        step_codes.push_back('{base + run_cnt, 1'b0, done});
      end else begin
        step_codes.push_back('{base + ESCAPE_CODE, 1'b0, 1'b0});
        step_codes.push_back('{run_cnt, 1'b0, done});
      end
    endfunction

    // predict the bytes caused by one accepted pixel request
    function void encode_pixel(logic [PIXEL_W-1:0] word, logic eof);
      logic [VAL_W-1:0] v;
      step_codes.delete();
      v = word[8*chan_sel + 3 +: VAL_W];
      if (!in_frame) begin
        run_val  = v;
        run_cnt  = 8'd1;
        in_frame = 1'b1;
      end else if (v == run_val && run_cnt < limit) begin
        run_cnt = run_cnt + 1'b1;
      end else begin
        close_run(1'b0);
        run_val = v;
        run_cnt = 8'd1;
      end
      if (eof) begin
        close_run(1'b1);
        run_val  = '0;
        run_cnt  = '0;
        in_frame = 1'b0;
      end
      if (step_codes.size() > 0) begin
        step_codes[step_codes.size()-1].last = 1'b1;
      end
      foreach (step_codes[i]) owed_codes.push_back(step_codes[i]);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_code(logic [CODE_W-1:0] code, logic last, logic done);
      code_rec_t want;
      codes_seen++;
      if (owed_codes.size() == 0) begin
        report_mismatch($sformatf("code byte %02h arrived with nothing owed", code));
      end else begin
        want = owed_codes.pop_front();
        if (code !== want.code)
          report_mismatch($sformatf("code_byte %02h, want %02h", code, want.code));
        if (last !== want.last)
          report_mismatch($sformatf("last_of_item %b, want %b (byte %02h)",
                                    last, want.last, want.code));
        if (done !== want.done)
          report_mismatch($sformatf("frame_done %b, want %b (byte %02h)",
                                    done, want.done, want.code));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIXEL_W-1:0]    in_pixel_word = '0;
  logic                  in_end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CODE_W-1:0]     out_code_byte;
  logic                  out_last_of_item;
  logic                  out_frame_done;

  rle_scoreboard sb = new();

  bit  steady = 1'b0;      // set during the stretch with no idling
  int  quiet_cycles = 0;
  int  pixels_sent = 0;
  int  frames_sent = 0;
  int  settings = 0;
  logic [CHAN_W-1:0] cur_chan = CHANNEL_RESET;

  pixel_channel_run_length_encoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_word    (in_pixel_word),
    .in_end_of_frame  (in_end_of_frame),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_byte    (out_code_byte),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

  always #1 clk = ~clk;

  // idle with a chance of 21 in 100 each time, never while the steady stretch runs
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  // receiver: sample the byte at the edge, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_code(out_code_byte, out_last_of_item, out_frame_done);
    end
    out_stall <= take_break();
  end

  // watchdog: any handshake on either side restarts the count
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles with no handshake", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one pixel request; optional gap first, then hold until accepted
  task automatic send_pixel(input logic [PIXEL_W-1:0] word, input logic eof);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_pixel_word   <= word;
    in_end_of_frame <= eof;
    do @(posedge clk); while (in_stall);
    sb.encode_pixel(word, eof);
    pixels_sent++;
    if (eof) frames_sent++;
  endtask

  // sender holds off until every owed byte is out, then lets the block settle
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // back-to-back register writes, cfg_we held high across them; the spare
  // write goes to an index with no register behind it
  task automatic configure(input logic [CFG_DATA_W-1:0] chan_data,
                           input logic [CFG_DATA_W-1:0] limit_data);
    logic [CFG_IDX_W-1:0] spare_idx;
    spare_idx = $urandom_range(1) ? UNUSED_REG_A : UNUSED_REG_B;
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHANNEL_SELECT;
    cfg_data  <= chan_data;
    @(posedge clk);
    sb.set_reg(REG_CHANNEL_SELECT, chan_data);
    cfg_index <= REG_RUN_LIMIT;
    cfg_data  <= limit_data;
    @(posedge clk);
    sb.set_reg(REG_RUN_LIMIT, limit_data);
    cfg_index <= spare_idx;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    sb.set_reg(spare_idx, cfg_data);
    cfg_we   <= 1'b0;
    cur_chan = chan_data[CHAN_W-1:0];
    settings++;
  endtask

  // random pixel word whose selected channel carries value v
  function automatic logic [PIXEL_W-1:0] pixel_of(input logic [VAL_W-1:0] v);
    logic [PIXEL_W-1:0] word;
    word = $urandom;
    word[8*cur_chan + 3 +: VAL_W] = v;
    return word;
  endfunction

  // mostly whole runs of one value with random filler bits, some frame ends
  // at run boundaries, the rest plain noise with the odd stray frame end
  task automatic random_phase(input int count);
    int               sent;
    int               len;
    bit               eof_at_end;
    logic [VAL_W-1:0] v;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 12) begin
        send_pixel($urandom, $urandom_range(19) == 0);
        sent++;
      end else begin
        // a small palette makes adjacent runs collide now and then
        v          = $urandom_range(3) == 0 ? VAL_W'($urandom) : VAL_W'($urandom_range(3));
        len        = $urandom_range(4) == 0 ? $urandom_range(7, 40) : $urandom_range(1, 8);
        eof_at_end = $urandom_range(3) == 0;
        for (int i = 0; i < len; i++) begin
          send_pixel(pixel_of(v), eof_at_end && i == len - 1);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int lim;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, reset settings first: byte 0, limit 255
    // single-pixel frame at the top value
    send_pixel(32'hFFFF_FFFF, 1'b1);
    // low three bits do not matter, short run then a one-pixel flush
    send_pixel(32'h0000_0007, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_00F8, 1'b1);
    // eight equal pixels take the escape form, frame ends on a new value
    for (int i = 0; i < 8; i++) send_pixel({24'($urandom), 8'h50 | 8'($urandom_range(7))}, 1'b0);
    send_pixel(32'h00FF_FF48, 1'b1);

    // byte 3 through a write with the upper data bits set
    drain_and_settle();
    configure(8'hFF, 8'd255);
    for (int i = 0; i < 9; i++) send_pixel({8'h18 | 8'($urandom_range(7)), 24'($urandom)}, 1'b0);
    // limit dropped below the open run: it closes on the next pixel,
    // and a limit of zero closes every run after one pixel
    drain_and_settle();
    configure(8'h03, 8'd0);
    send_pixel(32'h1B00_0000, 1'b1);
    send_pixel(32'hF8A5_5A00, 1'b0);
    send_pixel(32'hFF00_0000, 1'b1);

    // random part: one setting per phase, extremes of both registers
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       lim = 255;
        1:       lim = 7;
        2:       lim = 0;
        3:       lim = 1;
        4:       lim = 6;
        5:       lim = 8;
        6:       lim = 2;
        7:       lim = $urandom_range(9, 254);
        8:       lim = 255;
        default: lim = $urandom_range(255);
      endcase
      drain_and_settle();
      configure({6'($urandom), 2'(p % 4)}, 8'(lim));
      steady = (p == 5);
      random_phase(PHASE_PIXELS);
    end
    steady = 1'b0;

    // wind down: everything owed must come out, then a few quiet cycles
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d pixels in %0d frames over %0d register settings", pixels_sent,
             frames_sent, settings);
    $display("checked %0d code bytes, %0d mismatches", sb.codes_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
